// ===== src/sorted_table_floor_ceil_search_top_macros.svh =====
// ----------------------------------------------------------------------------
// Sorted table floor/ceiling search - assertion macros
// Concurrent assertion shorthands, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_FLOOR_CEIL_SEARCH_TOP_MACROS_SVH
`define SORTED_TABLE_FLOOR_CEIL_SEARCH_TOP_MACROS_SVH

// Same-cycle implication.
`define STFC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define STFC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/stfc_pkg.sv =====
// ----------------------------------------------------------------------------
// stfc_pkg
// Types and constants shared by the sorted table floor/ceiling search.
// ----------------------------------------------------------------------------
package stfc_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned COUNT_W = 11;

  // Value reported when no entry qualifies.
  localparam logic signed [DATA_W-1:0] NOT_FOUND = -32'sd1;

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    KIND_FLOOR = 1'b0,
    KIND_CEIL  = 1'b1
  } search_kind_e;

  typedef enum logic [0:0] {
    ST_IDLE   = 1'b0,
    ST_SEARCH = 1'b1
  } state_e;

  typedef struct packed {
    op_e                      operation;
    logic [SLOT_W-1:0]        slot_index;
    logic signed [DATA_W-1:0] data_word;
  } in_item_t;

  typedef struct packed {
    logic                     floor_found;
    logic signed [DATA_W-1:0] floor_value;
    logic                     ceil_found;
    logic signed [DATA_W-1:0] ceil_value;
  } out_item_t;

  // Search lane status toward the sequencer.
  typedef struct packed {
    logic busy;
    logic found;
  } lane_sts_t;

endpackage

// ===== src/stfc_ram.sv =====
// ----------------------------------------------------------------------------
// stfc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module stfc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/stfc_lane.sv =====
// ----------------------------------------------------------------------------
// stfc_lane
// One binary search lane: bounds, compare and step, one probe per cycle.
// ----------------------------------------------------------------------------
`include "sorted_table_floor_ceil_search_top_macros.svh"

module stfc_lane #(
  parameter int unsigned ADDR_W = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  stfc_pkg::search_kind_e              kind_i,
  input  logic                                start_i,
  input  logic [ADDR_W:0]                     count_i,
  input  logic signed [stfc_pkg::DATA_W-1:0]  key_i,
  input  logic signed [stfc_pkg::DATA_W-1:0]  rdata_i,
  output logic [ADDR_W-1:0]                   raddr_o,
  output stfc_pkg::lane_sts_t                 sts_o,
  output logic signed [stfc_pkg::DATA_W-1:0]  value_o
);
  import stfc_pkg::*;

  // lo and hi+1 bounds; the window is empty once lo reaches hi+1
  logic [ADDR_W:0]          lo_q, lo_d;
  logic [ADDR_W:0]          hip1_q, hip1_d;
  logic                     found_q, found_d;
  logic signed [DATA_W-1:0] value_q, value_d;
  logic signed [DATA_W-1:0] key_q, key_d;
  logic [ADDR_W:0]          span;
  logic [ADDR_W-1:0]        mid;
  logic                     busy;
  logic                     hit;
  logic                     go_right;

  function automatic logic [ADDR_W-1:0] mid_of(input logic [ADDR_W:0] lo,
                                                input logic [ADDR_W:0] hip1);
    logic [ADDR_W+1:0] sum;
    sum = {1'b0, lo} + {1'b0, hip1} - {{(ADDR_W+1){1'b0}}, 1'b1};
    return sum[ADDR_W:1];
  endfunction

  assign busy = (lo_q < hip1_q);
  assign span = hip1_q - lo_q;
  assign mid  = mid_of(lo_q, hip1_q);

  always_comb begin
    if (kind_i == KIND_FLOOR) begin
      hit      = (rdata_i <= key_q);
      go_right = hit;
    end else begin
      hit      = (key_q <= rdata_i);
      go_right = !hit;
    end
  end

  always_comb begin
    lo_d    = lo_q;
    hip1_d  = hip1_q;
    found_d = found_q;
    value_d = value_q;
    key_d   = key_q;
    if (start_i) begin
      lo_d    = '0;
      hip1_d  = count_i;
      found_d = 1'b0;
      key_d   = key_i;
    end else if (busy) begin
      if (hit) begin
        found_d = 1'b1;
        value_d = rdata_i;
      end
      if (go_right) begin
        lo_d = {1'b0, mid} + {{ADDR_W{1'b0}}, 1'b1};
      end else begin
        hip1_d = {1'b0, mid};
      end
    end
  end

  // Address the probe of the next window so its data lands with it.
  assign raddr_o = mid_of(lo_d, hip1_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q    <= '0;
      hip1_q  <= '0;
      found_q <= 1'b0;
    end else begin
      lo_q    <= lo_d;
      hip1_q  <= hip1_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    key_q   <= key_d;
  end

  assign sts_o.busy  = busy;
  assign sts_o.found = found_q;
  assign value_o     = found_q ? value_q : NOT_FOUND;

  `STFC_ASSERT_IMP(a_bounds_ordered, 1'b1, lo_q <= hip1_q, "lane bounds crossed")
  `STFC_ASSERT_NXT(a_window_shrinks, busy && !start_i, span < $past(span),
                   "lane window did not shrink")
  `STFC_ASSERT_IMP(a_hit_qualifies,
                   found_q && !start_i,
                   (kind_i == KIND_FLOOR) ? (value_q <= key_q) : (key_q <= value_q),
                   "lane holds a value on the wrong side of the key")

endmodule

// ===== src/sorted_table_floor_ceil_search_top.sv =====
// ----------------------------------------------------------------------------
// sorted_table_floor_ceil_search_top
// Floor and ceiling lookup over a table of signed words kept in ascending order.
// ----------------------------------------------------------------------------
// Software fills the table one slot per load transfer (operation 0), in
// ascending order, and sets entry_count through the config port while the
// block is idle; counts above TABLE_DEPTH are clamped. A query transfer
// (operation 1) binary-searches the first entry_count slots and returns one
// result transfer: the largest entry not above the key and the smallest entry
// not below it, each with a found flag (value reads -1 when the flag is 0).
// A load returns nothing; a load to a slot past the table is dropped. After
// accepting a query the block holds the input stalled until the result is
// handed to the output register. The query is done in steps: accept the
// query and start both searches, one table read and compare per probe until
// the longer of the two searches ends, then hand the result to the output
// register, which waits while a previous result is still held by a stalled
// output. The floor and ceiling searches run side by side, each on its own
// copy of the table so each gets one read per cycle. Slots never loaded must
// not fall in the searched range; the table is not cleared by reset.
// ----------------------------------------------------------------------------
`include "sorted_table_floor_ceil_search_top_macros.svh"

module sorted_table_floor_ceil_search_top #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // item input
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  stfc_pkg::in_item_t              in_data_i,
  // result output
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output stfc_pkg::out_item_t             out_data_o,
  // entry_count register write
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [stfc_pkg::COUNT_W-1:0]    cfg_data_i
);
  import stfc_pkg::*;

  localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W  = ADDR_W + 1;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               out_valid_q;
  out_item_t          out_q;

  logic               slot_ok;
  logic               lanes_done;
  logic               out_free;
  logic               accept;
  logic               start;
  logic               ram_we;
  logic               capture;

  logic [ADDR_W-1:0]  waddr;
  logic [ADDR_W-1:0]  fl_raddr, ce_raddr;
  logic [DATA_W-1:0]  fl_rdata, ce_rdata;
  lane_sts_t          fl_sts, ce_sts;
  logic signed [DATA_W-1:0] fl_value, ce_value;

  // Config: always ready; clamp the count to the table size on write.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    count_d = count_q;
    if (cfg_valid_i) begin
      if (32'(cfg_data_i) > TABLE_DEPTH) begin
        count_d = CNT_W'(TABLE_DEPTH);
      end else begin
        count_d = CNT_W'(cfg_data_i);
      end
    end
  end

  assign slot_ok    = (32'(in_data_i.slot_index) < TABLE_DEPTH);
  assign waddr      = ADDR_W'(in_data_i.slot_index);
  assign lanes_done = !fl_sts.busy && !ce_sts.busy;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (in_data_i.operation == OP_QUERY)) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (lanes_done && out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_stall_o = 1'b1;
    accept     = 1'b0;
    start      = 1'b0;
    ram_we     = 1'b0;
    capture    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        accept     = in_valid_i;
        start      = accept && (in_data_i.operation == OP_QUERY);
        ram_we     = accept && (in_data_i.operation == OP_LOAD) && slot_ok;
      end
      ST_SEARCH: begin
        capture = lanes_done && out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      // Hold the result until the downstream side takes it.
      if (capture) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture) begin
      out_q.floor_found <= fl_sts.found;
      out_q.floor_value <= fl_value;
      out_q.ceil_found  <= ce_sts.found;
      out_q.ceil_value  <= ce_value;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Table copies: both written on a load, each read by one lane.
  stfc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_floor_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (in_data_i.data_word),
    .raddr_i (fl_raddr),
    .rdata_o (fl_rdata)
  );

  stfc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ceil_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (in_data_i.data_word),
    .raddr_i (ce_raddr),
    .rdata_o (ce_rdata)
  );

  stfc_lane #(
    .ADDR_W (ADDR_W)
  ) u_floor_lane (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .kind_i  (KIND_FLOOR),
    .start_i (start),
    .count_i (count_q),
    .key_i   (in_data_i.data_word),
    .rdata_i (fl_rdata),
    .raddr_o (fl_raddr),
    .sts_o   (fl_sts),
    .value_o (fl_value)
  );

  stfc_lane #(
    .ADDR_W (ADDR_W)
  ) u_ceil_lane (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .kind_i  (KIND_CEIL),
    .start_i (start),
    .count_i (count_q),
    .key_i   (in_data_i.data_word),
    .rdata_i (ce_rdata),
    .raddr_o (ce_raddr),
    .sts_o   (ce_sts),
    .value_o (ce_value)
  );

  `STFC_ASSERT_IMP(a_idle_lanes_quiet, state_q == ST_IDLE,
                   !fl_sts.busy && !ce_sts.busy, "search lane busy while idle")
  `STFC_ASSERT_NXT(a_capture_shows, capture, out_valid_o && !in_stall_o,
                   "captured result not presented or input still stalled")
  `STFC_ASSERT_IMP(a_result_from_search, $rose(out_valid_o),
                   $past(state_q) == ST_SEARCH, "result appeared without a search")

endmodule

// ===== tb/sv/stfc_bounds_monitor.sv =====
// ----------------------------------------------------------------------------
// stfc_bounds_monitor
// Watches the item, result and entry_count channels of the floor/ceiling
// search, keeps its own copy of the table, predicts each query's bounds and
// compares every result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module stfc_bounds_monitor #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  stfc_pkg::in_item_t           in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  stfc_pkg::out_item_t          out_data_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [stfc_pkg::COUNT_W-1:0] cfg_data_i,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import stfc_pkg::*;

  logic signed [DATA_W-1:0] entries_m [TABLE_DEPTH];
  logic [COUNT_W-1:0]       count_m;
  out_item_t                bounds_q [$];

  // Leftmost entry >= key and rightmost entry <= key, same probe order as the
  // block: midpoint rounded down, both searches over the clamped count.
  function automatic out_item_t search_bounds(input logic signed [DATA_W-1:0] key);
    int        lo;
    int        hi;
    int        mid;
    int        span;
    out_item_t res;
    span = (count_m > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_m);
    res.floor_found = 1'b0;
    res.floor_value = NOT_FOUND;
    res.ceil_found  = 1'b0;
    res.ceil_value  = NOT_FOUND;
    lo = 0;
    hi = span - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (key <= entries_m[mid]) begin
        res.ceil_found = 1'b1;
        res.ceil_value = entries_m[mid];
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    lo = 0;
    hi = span - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (entries_m[mid] <= key) begin
        res.floor_found = 1'b1;
        res.floor_value = entries_m[mid];
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("%0t ns MISMATCH %s: got %h, expected %h", $time, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      count_m = '0;
      bounds_q.delete();
      pending_o    = 0;
      fail_count_o = 0;
      checked_o    = 0;
    end else begin
      // Retire results first: a query accepted on this edge cannot be answered yet.
      if (out_valid_i && !out_stall_i) begin
        if (bounds_q.size() == 0) begin
          report_mismatch("result with no query waiting", out_data_i.floor_value, '0);
        end else begin
          want = bounds_q.pop_front();
          checked_o++;
          if (out_data_i.floor_found !== want.floor_found)
            report_mismatch("floor_found", DATA_W'(out_data_i.floor_found),
                            DATA_W'(want.floor_found));
          if (out_data_i.floor_value !== want.floor_value)
            report_mismatch("floor_value", out_data_i.floor_value, want.floor_value);
          if (out_data_i.ceil_found !== want.ceil_found)
            report_mismatch("ceil_found", DATA_W'(out_data_i.ceil_found),
                            DATA_W'(want.ceil_found));
          if (out_data_i.ceil_value !== want.ceil_value)
            report_mismatch("ceil_value", out_data_i.ceil_value, want.ceil_value);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.operation == OP_QUERY)
          bounds_q.push_back(search_bounds(in_data_i.data_word));
        else if (in_data_i.slot_index < TABLE_DEPTH)
          entries_m[in_data_i.slot_index] = in_data_i.data_word;
      end
      if (cfg_valid_i && cfg_ready_i)
        count_m = cfg_data_i;
      pending_o = bounds_q.size();
    end
  end

endmodule

// ===== tb/sv/sorted_table_floor_ceil_search_top_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_table_floor_ceil_search_top_tb
// Drives loads, queries and entry_count writes into the floor/ceiling search
// with random idling on both channels; a separate monitor predicts and checks
// every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module sorted_table_floor_ceil_search_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import stfc_pkg::*;

  localparam int unsigned TABLE_DEPTH   = 1024;
  localparam int unsigned RANDOM_ITEMS  = 700;
  localparam int unsigned IDLE_PCT      = 18;
  // Settle time given to the block after the last result.
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_stall;
  out_item_t          out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_data;

  // While calm is set neither side idles: one long stretch at full rate.
  logic               calm = 1'b0;

  int                 fail_count;
  int                 pending;
  int                 checked;
  int                 cycle_cnt;
  int                 items_sent = 0;
  int                 loads_sent = 0;
  int                 queries_sent = 0;
  int                 cfg_writes = 0;
  int unsigned        count_sh = 0;

  // Words loaded so far, used only to aim query keys at and around real entries.
  logic signed [DATA_W-1:0] loaded_words [TABLE_DEPTH];

  sorted_table_floor_ceil_search_top #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  stfc_bounds_monitor #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) bounds_mon (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stall the result side at random, except in the calm stretch.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // Watchdog: count cycles and end the run if the traffic never drains.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding", cycle_cnt, pending);
    $display("sorted_table_floor_ceil_search_top_tb NOT OK");
    $finish;
  end

  // Hold one item on the input until the block takes it; idle first at random.
  task automatic send_item(input in_item_t item);
    while (!calm && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_load(input int unsigned slot, input logic signed [DATA_W-1:0] word);
    in_item_t item;
    item.operation  = OP_LOAD;
    item.slot_index = slot[SLOT_W-1:0];
    item.data_word  = word;
    loaded_words[slot[SLOT_W-1:0]] = word;
    loads_sent++;
    send_item(item);
  endtask

  // Queries carry a random slot_index too, which the block must ignore.
  task automatic send_query(input logic signed [DATA_W-1:0] key);
    in_item_t item;
    item.operation  = OP_QUERY;
    item.slot_index = SLOT_W'($urandom_range(TABLE_DEPTH - 1));
    item.data_word  = key;
    queries_sent++;
    send_item(item);
  endtask

  // Drop valid, wait until every query is answered, then let the block settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write entry_count; only called while the block is idle.
  task automatic write_entry_count(input int unsigned n);
    cfg_valid <= 1'b1;
    cfg_data  <= COUNT_W'(n);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    count_sh = n;
    cfg_writes++;
  endtask

  // Load slots 0..n-1 in ascending order: clustered with duplicates, spread
  // across the whole range (saturating at the top), or a moderate climb.
  task automatic load_ascending(input int unsigned n);
    longint cur;
    longint stride_max;
    case ($urandom_range(2))
      0: begin
        cur = $signed($urandom);
        stride_max = 2;
      end
      1: begin
        cur = longint'(WORD_MIN) + $urandom_range(3);
        stride_max = 64'd8589934590 / n;
        if (stride_max > 64'd4294967295) stride_max = 64'd4294967295;
      end
      default: begin
        cur = $signed($urandom);
        stride_max = 5000;
      end
    endcase
    for (int unsigned k = 0; k < n; k++) begin
      if (cur > longint'(WORD_MAX)) cur = longint'(WORD_MAX);
      send_load(k, cur[DATA_W-1:0]);
      cur += $urandom_range(stride_max[31:0]);
    end
  endtask

  // Mostly keys on or next to a loaded entry, some extremes, the rest anywhere.
  function automatic logic signed [DATA_W-1:0] pick_key();
    int unsigned span;
    int unsigned r;
    logic signed [DATA_W-1:0] word;
    span = (count_sh > TABLE_DEPTH) ? TABLE_DEPTH : count_sh;
    r = $urandom_range(99);
    if (span > 0 && r < 60) begin
      word = loaded_words[$urandom_range(span - 1)];
      case ($urandom_range(2))
        0:       return word - 1;
        1:       return word;
        default: return word + 1;
      endcase
    end
    if (r < 70) return $urandom_range(1) ? WORD_MAX : WORD_MIN;
    return $urandom;
  endfunction

  initial begin
    logic signed [DATA_W-1:0] sorted_keys [9];
    int unsigned r;
    int unsigned n_entries;
    int          rand_base;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table right after reset: both flags clear, both values -1.
    send_query(32'sd0);
    send_query(-32'sd1);

    // Small sorted table holding both extremes and a real -1 entry.
    send_load(0, WORD_MIN);
    send_load(1, -32'sd5);
    send_load(2, -32'sd1);
    send_load(3, 32'sd0);
    send_load(4, 32'sd100);
    send_load(5, WORD_MAX);
    wait_idle();
    write_entry_count(6);
    sorted_keys = '{WORD_MIN, WORD_MAX, -32'sd1, -32'sd3, -32'sd2147483647,
                    32'sd50, 32'sd0, 32'sd101, -32'sd6};
    foreach (sorted_keys[k]) send_query(sorted_keys[k]);

    // Break the ordering; the probes still follow their fixed path.
    send_load(2, 32'sd500);
    send_query(32'sd200);
    send_query(-32'sd1);
    wait_idle();

    // Fill the whole table with no idling on either side, then search it with
    // a count past the depth (clamped) and with the exact depth.
    calm <= 1'b1;
    load_ascending(TABLE_DEPTH);
    wait_idle();
    write_entry_count(2047);
    repeat (40) send_query(pick_key());
    wait_idle();
    write_entry_count(TABLE_DEPTH);
    repeat (30) send_query(pick_key());
    wait_idle();
    calm <= 1'b0;

    // Random phases: mostly small tables reloaded in order, some empty or
    // oversize counts, and a few stray loads that break the ordering.
    rand_base = items_sent;
    while (items_sent - rand_base < RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (r < 8)       n_entries = 0;
      else if (r < 14) n_entries = $urandom_range(2047, TABLE_DEPTH + 1);
      else if (r < 20) n_entries = $urandom_range(TABLE_DEPTH, 100);
      else             n_entries = $urandom_range(24, 1);
      write_entry_count(n_entries);
      if (n_entries >= 1 && n_entries <= 64) load_ascending(n_entries);
      repeat ($urandom_range(30, 8)) begin
        if ($urandom_range(99) < 10) send_load($urandom_range(TABLE_DEPTH - 1), $urandom);
        else send_query(pick_key());
      end
      wait_idle();
    end

    $display("Covered %0d loads and %0d queries across %0d entry_count writes,",
             loads_sent, queries_sent, cfg_writes);
    $display("including empty, full and clamped counts; %0d results checked, %0d mismatches.",
             checked, fail_count);
    if (fail_count == 0) begin
      $display("sorted_table_floor_ceil_search_top_tb OK");
    end else begin
      $display("sorted_table_floor_ceil_search_top_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/stfc_pkg.sv
src/stfc_ram.sv
src/stfc_lane.sv
src/sorted_table_floor_ceil_search_top.sv
tb/sv/stfc_bounds_monitor.sv
tb/sv/sorted_table_floor_ceil_search_top_tb.sv
